// ----- design/read_mismatch_quality_summary_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the read mismatch-quality summary block
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef READ_MISMATCH_QUALITY_SUMMARY_DEFINES_SVH
`define READ_MISMATCH_QUALITY_SUMMARY_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RMQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmqs assertion failed");

// Next-cycle implication, disabled while in reset.
`define RMQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmqs assertion failed");

`endif

// ----- design/rmqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rmqs_pkg
// Types and constants of the read mismatch-quality summary block.
// ----------------------------------------------------------------------------
package rmqs_pkg;

    localparam int MAX_READ_LEN = 4096;
    localparam int CNT_W        = 13;      // holds 0..MAX_READ_LEN
    localparam int IDX_W        = CNT_W + 1;

    localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_READ_LEN);

    // op codes (stream tuser)
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_ALIGNED  = 3'd1;
    localparam logic [2:0] OP_DELETION = 3'd2;
    localparam logic [2:0] OP_INSERT   = 3'd3;
    localparam logic [2:0] OP_SOFTCLIP = 3'd4;
    localparam logic [2:0] OP_END      = 3'd5;

    localparam logic [3:0]  BASE_UNKNOWN = 4'h0;
    localparam logic [3:0]  BASE_N       = 4'hF;
    localparam logic [7:0]  TAIL_QUAL    = 8'd2;
    localparam logic [19:0] SUM_MAX      = 20'hFFFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [30:0] ref_start;
        logic [12:0] read_length;
        logic        reverse;
        logic [3:0]  read_nt;
        logic [3:0]  ref_nt;
        logic [7:0]  quality;
        logic [27:0] del_length;
        logic        first_of_run;
    } item_t;

    typedef struct packed {
        logic [19:0]        mismatch_quality_sum;
        logic signed [13:0] kept_len;
        logic [12:0]        head_clip;
        logic signed [13:0] end3_bound;
        logic signed [12:0] q2_position;
        logic               aborted;
    } summary_t;

endpackage

// ----- design/rmqs_acc.sv -----
// ----------------------------------------------------------------------------
// rmqs_acc
// Per-read accounting state; one item applied per cycle, summary is combinational.
// ----------------------------------------------------------------------------
module rmqs_acc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  rmqs_pkg::item_t    item,
    input  logic [30:0]        ref_length_limit,
    output rmqs_pkg::summary_t summary
);
    import rmqs_pkg::*;

    logic [31:0]             ref_pos_reg,      ref_pos_next;
    logic [CNT_W-1:0]        rd_idx_reg,       rd_idx_next;
    logic [CNT_W-1:0]        base_cnt_reg,     base_cnt_next;
    logic [19:0]             mm_sum_reg,       mm_sum_next;
    logic                    mm_valid_reg,     mm_valid_next;
    logic [CNT_W-1:0]        mm_idx_reg,       mm_idx_next;
    logic [7:0]              mm_qual_reg,      mm_qual_next;
    logic [CNT_W-1:0]        lclip_reg,        lclip_next;
    logic signed [IDX_W-1:0] rclip_edge_reg,   rclip_edge_next;
    logic signed [IDX_W-1:0] unclip_reg,       unclip_next;
    logic                    clip_left_reg,    clip_left_next;
    logic                    still_valid_reg,  still_valid_next;
    logic                    strand_rev_reg,   strand_rev_next;
    logic [CNT_W-1:0]        read_len_reg,     read_len_next;
    logic                    tail_found_reg,   tail_found_next;
    logic [CNT_W-1:0]        tail_idx_reg,     tail_idx_next;

    logic [32:0]             ref_inc;
    logic [32:0]             ref_del;
    logic [31:0]             ref_pos_p1;
    logic [31:0]             ref_pos_pdel;
    logic [20:0]             sum_add;
    logic [19:0]             sum_sat;
    logic                    abort_hit;
    logic                    mismatch;
    logic                    mm_adjacent;
    logic [CNT_W-1:0]        len_clamp;
    logic signed [IDX_W-1:0] q2;
    logic signed [IDX_W-1:0] len_m1;
    logic signed [IDX_W-1:0] lclip_s;
    logic signed [IDX_W-1:0] tpi;

    // saturating adders and compares
    assign ref_inc      = {1'b0, ref_pos_reg} + 33'd1;
    assign ref_pos_p1   = ref_inc[32] ? 32'hFFFF_FFFF : ref_inc[31:0];
    assign ref_del      = {1'b0, ref_pos_reg} + {5'b0, item.del_length};
    assign ref_pos_pdel = ref_del[32] ? 32'hFFFF_FFFF : ref_del[31:0];
    assign sum_add      = {1'b0, mm_sum_reg} + {13'b0, mm_qual_reg};
    assign sum_sat      = sum_add[20] ? SUM_MAX : sum_add[19:0];
    assign abort_hit    = (ref_length_limit != 31'd0) &&
                          (ref_pos_reg > {1'b0, ref_length_limit});
    assign mismatch     = (item.read_nt != item.ref_nt) && (item.ref_nt != BASE_N) &&
                          (item.read_nt != BASE_UNKNOWN);
    assign mm_adjacent  = (({1'b0, mm_idx_reg} + IDX_W'(1)) == {1'b0, rd_idx_reg});
    assign len_clamp    = (item.read_length > LEN_MAX) ? LEN_MAX : item.read_length;

    always_comb
    begin
        ref_pos_next     = ref_pos_reg;
        rd_idx_next      = rd_idx_reg;
        base_cnt_next    = base_cnt_reg;
        mm_sum_next      = mm_sum_reg;
        mm_valid_next    = mm_valid_reg;
        mm_idx_next      = mm_idx_reg;
        mm_qual_next     = mm_qual_reg;
        lclip_next       = lclip_reg;
        rclip_edge_next  = rclip_edge_reg;
        unclip_next      = unclip_reg;
        clip_left_next   = clip_left_reg;
        still_valid_next = still_valid_reg;
        strand_rev_next  = strand_rev_reg;
        read_len_next    = read_len_reg;
        tail_found_next  = tail_found_reg;
        tail_idx_next    = tail_idx_reg;

        if (item_valid)
        begin
            case (item.op)
                OP_START:
                begin
                    ref_pos_next     = {1'b0, item.ref_start};
                    rd_idx_next      = '0;
                    base_cnt_next    = '0;
                    mm_sum_next      = '0;
                    mm_valid_next    = 1'b0;
                    mm_idx_next      = '0;
                    mm_qual_next     = '0;
                    lclip_next       = '0;
                    rclip_edge_next  = $signed({1'b0, len_clamp});
                    unclip_next      = $signed({1'b0, len_clamp});
                    clip_left_next   = 1'b0;
                    still_valid_next = 1'b1;
                    strand_rev_next  = item.reverse;
                    read_len_next    = len_clamp;
                    tail_found_next  = 1'b0;
                    tail_idx_next    = '0;
                end
                OP_DELETION:
                begin
                    if (still_valid_reg)
                    begin
                        ref_pos_next = ref_pos_pdel;
                    end
                end
                OP_ALIGNED, OP_INSERT, OP_SOFTCLIP:
                begin
                    if (base_cnt_reg < LEN_MAX)
                    begin
                        base_cnt_next = base_cnt_reg + CNT_W'(1);
                        // quality-2 tail scan sees every base, even after abort
                        if ((base_cnt_reg < read_len_reg) && (item.quality != TAIL_QUAL))
                        begin
                            if (!strand_rev_reg || !tail_found_reg)
                            begin
                                tail_idx_next = base_cnt_reg;
                            end
                            tail_found_next = 1'b1;
                        end
                        if (still_valid_reg)
                        begin
                            if (item.op == OP_ALIGNED)
                            begin
                                if (abort_hit)
                                begin
                                    still_valid_next = 1'b0;
                                end
                                else
                                begin
                                    if (mismatch)
                                    begin
                                        // adjacent mismatches keep only the run max
                                        if (mm_valid_reg && !mm_adjacent)
                                        begin
                                            mm_sum_next  = sum_sat;
                                            mm_qual_next = item.quality;
                                        end
                                        else if (!mm_valid_reg ||
                                                 (mm_qual_reg < item.quality))
                                        begin
                                            mm_qual_next = item.quality;
                                        end
                                        mm_idx_next   = rd_idx_reg;
                                        mm_valid_next = 1'b1;
                                    end
                                    ref_pos_next = ref_pos_p1;
                                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                                end
                            end
                            else if (item.op == OP_INSERT)
                            begin
                                rd_idx_next = rd_idx_reg + CNT_W'(1);
                            end
                            else
                            begin
                                if (item.first_of_run)
                                begin
                                    clip_left_next = (rd_idx_reg == '0);
                                end
                                if (clip_left_next)
                                begin
                                    lclip_next = lclip_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    rclip_edge_next = rclip_edge_reg - IDX_W'(1);
                                end
                                rd_idx_next = rd_idx_reg + CNT_W'(1);
                                unclip_next = unclip_reg - IDX_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_pos_reg     <= '0;
            rd_idx_reg      <= '0;
            base_cnt_reg    <= '0;
            mm_sum_reg      <= '0;
            mm_valid_reg    <= 1'b0;
            mm_idx_reg      <= '0;
            mm_qual_reg     <= '0;
            lclip_reg       <= '0;
            rclip_edge_reg  <= '0;
            unclip_reg      <= '0;
            clip_left_reg   <= 1'b0;
            still_valid_reg <= 1'b1;
            strand_rev_reg  <= 1'b0;
            read_len_reg    <= '0;
            tail_found_reg  <= 1'b0;
            tail_idx_reg    <= '0;
        end
        else
        begin
            ref_pos_reg     <= ref_pos_next;
            rd_idx_reg      <= rd_idx_next;
            base_cnt_reg    <= base_cnt_next;
            mm_sum_reg      <= mm_sum_next;
            mm_valid_reg    <= mm_valid_next;
            mm_idx_reg      <= mm_idx_next;
            mm_qual_reg     <= mm_qual_next;
            lclip_reg       <= lclip_next;
            rclip_edge_reg  <= rclip_edge_next;
            unclip_reg      <= unclip_next;
            clip_left_reg   <= clip_left_next;
            still_valid_reg <= still_valid_next;
            strand_rev_reg  <= strand_rev_next;
            read_len_reg    <= read_len_next;
            tail_found_reg  <= tail_found_next;
            tail_idx_reg    <= tail_idx_next;
        end
    end

    // summary from the current state
    assign q2      = tail_found_reg ? ($signed({1'b0, tail_idx_reg}) - IDX_W'(1))
                                    : -IDX_W'(1);
    assign len_m1  = $signed({1'b0, read_len_reg}) - IDX_W'(1);
    assign lclip_s = $signed({1'b0, lclip_reg});

    always_comb
    begin
        if (strand_rev_reg)
        begin
            tpi = lclip_s;
            if (q2 > tpi)
            begin
                tpi = q2;
            end
        end
        else
        begin
            tpi = len_m1;
            if (rclip_edge_reg < tpi)
            begin
                tpi = rclip_edge_reg;
            end
            if ((q2 != -IDX_W'(1)) && (q2 < tpi))
            begin
                tpi = q2;
            end
        end
    end

    assign summary.mismatch_quality_sum = sum_sat;
    assign summary.kept_len             = unclip_reg;
    assign summary.head_clip            = lclip_reg;
    assign summary.end3_bound           = tpi;
    assign summary.q2_position          = q2[CNT_W-1:0];
    assign summary.aborted              = !still_valid_reg;

endmodule

// ----- design/read_mismatch_quality_summary.sv -----
// ----------------------------------------------------------------------------
// read_mismatch_quality_summary
// Streams one aligned read, item by item, and emits one quality summary per end word.
// ----------------------------------------------------------------------------
// Throughput is one input word per clock while s_axis_tready is high: every word
// is captured in an input register and applied to the per-read state in the next
// cycle by a single compare-and-add stage. An end word in the input register has
// its summary loaded into the result register, raising m_axis_tvalid, or into the
// skid entry while that one is full. The output side has a result register plus
// one skid entry; s_axis_tready drops while the skid entry is full, or while an
// end word sits in the input register and the result register is full. cfg_wdata
// (reference length limit, 0 = no bounds check) is loaded on any cycle with
// cfg_we high and should only change between reads, with no word in flight.
module read_mismatch_quality_summary (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: ref_start[30:0], read_length[43:31], reverse[44], read_nt[48:45],
    //        ref_nt[52:49], quality[60:53], del_length[88:61], first_of_run[89],
    //        zero pad[95:90]
    input  logic [95:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: mismatch_quality_sum[19:0], kept_len[33:20], head_clip[46:34],
    //        end3_bound[60:47], q2_position[73:61], aborted[74], zero pad[79:75]
    output logic [79:0] m_axis_tdata
);
    import rmqs_pkg::*;

    logic        limit_reg;
    logic [30:0] limit_val_reg;

    item_t       in_item;
    logic        stage_valid_reg;
    item_t       stage_item_reg;
    logic        stage_end;

    summary_t    summary;
    logic [79:0] summary_word;

    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        skid_valid_reg;
    logic [79:0] skid_data_reg;
    logic        in_take;
    logic        out_take;

    // unpack input word
    assign in_item.op           = s_axis_tuser;
    assign in_item.ref_start    = s_axis_tdata[30:0];
    assign in_item.read_length  = s_axis_tdata[43:31];
    assign in_item.reverse      = s_axis_tdata[44];
    assign in_item.read_nt      = s_axis_tdata[48:45];
    assign in_item.ref_nt       = s_axis_tdata[52:49];
    assign in_item.quality      = s_axis_tdata[60:53];
    assign in_item.del_length   = s_axis_tdata[88:61];
    assign in_item.first_of_run = s_axis_tdata[89];

    assign stage_end = stage_valid_reg && (stage_item_reg.op == OP_END);
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_take  = out_valid_reg && m_axis_tready;

    // Room check: a pending end word in the stage needs either the result
    // register or the skid entry; never accept more than we can hold.
    assign s_axis_tready = !skid_valid_reg && !(stage_end && out_valid_reg);

    // config register; limit_reg only marks that a write has happened
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= 1'b0;
            limit_val_reg <= '0;
        end
        else if (cfg_we)
        begin
            limit_reg     <= 1'b1;
            limit_val_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_item_reg <= in_item;
        end
    end

    rmqs_acc u_acc (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (stage_valid_reg),
        .item             (stage_item_reg),
        .ref_length_limit (limit_reg ? limit_val_reg : 31'd0),
        .summary          (summary)
    );

    assign summary_word = {5'b0,
                           summary.aborted,
                           summary.q2_position,
                           summary.end3_bound,
                           summary.head_clip,
                           summary.kept_len,
                           summary.mismatch_quality_sum};

    // result register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (stage_end)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (stage_end)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= summary_word;
            end
            else
            begin
                out_data_reg <= summary_word;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- design/rmqs_chk.sv -----
// ----------------------------------------------------------------------------
// rmqs_chk
// Port-level checks of the read mismatch-quality summary block, bound to the top.
// ----------------------------------------------------------------------------
`include "read_mismatch_quality_summary_defines.svh"

module rmqs_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [30:0] cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [95:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    import rmqs_pkg::*;

    // a waiting summary holds until taken
    `RMQS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a fresh summary only follows an accepted end word
    `RMQS_ASSERT_IMP(a_out_from_end, clk, rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_END), 2))

    // input stalls only while a summary is waiting
    `RMQS_ASSERT_IMP(a_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid)

endmodule

bind read_mismatch_quality_summary rmqs_chk u_rmqs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: read mismatch-quality summary testbench
// Streams aligned reads word by word into the block and tracks the same
// per-read state on the side, so that each end word predicts one summary.
// Summaries are checked field by field in order. Both stream sides stall at
// random, and the length limit is changed between reads once nothing is in
// flight.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmqs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;      // cycles of quiet before a limit change
    localparam int TAIL_WAIT   = 8;
    localparam int CALM_LO     = 400;    // window with no stalls on either side
    localparam int CALM_HI     = 900;
    localparam int PHASE_WORDS = 170;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef enum logic [1:0] {WORD_ITEM, DRAIN_WAIT, CFG_WRITE} feed_kind_t;

    typedef struct {
        feed_kind_t  kind;
        item_t       w;
        logic [30:0] limit;
    } feed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    read_mismatch_quality_summary u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    feed_t    feed_q[$];
    summary_t summary_q[$];
    item_t    cur_word;
    logic     in_fire = 1'b0;
    int       settle_cnt = 0;
    int       cycles = 0;
    int       errors = 0;
    int       n_words = 0;
    logic [30:0] gen_limit = '0;    // limit in force while the stimulus is built

    // Side copy of the block's per-read state, at reset values.
    logic [30:0] len_limit = '0;
    logic [31:0] ref_pos = '0;
    int          rd_idx = 0;
    int          base_cnt = 0;
    int unsigned mm_sum = 0;
    int          last_mm_idx = -1;
    int unsigned last_mm_q = 0;
    int          lclip = 0;
    int          rclip_edge = 0;
    int          unclipped = 0;
    bit          clip_left = 1'b0;
    bit          still_ok = 1'b1;
    bit          rev = 1'b0;
    int          rlen = 0;
    bit          tail_found = 1'b0;
    int          tail_idx = -1;

    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Every field random; callers override the ones the op uses.
    function automatic item_t rand_fields(logic [2:0] op);
        item_t w;
        w.op           = op;
        w.ref_start    = 31'($urandom);
        w.read_length  = 13'($urandom);
        w.reverse      = 1'($urandom);
        w.read_nt      = 4'($urandom);
        w.ref_nt       = 4'($urandom);
        w.quality      = 8'($urandom);
        w.del_length   = 28'($urandom);
        w.first_of_run = 1'($urandom);
        return w;
    endfunction

    function automatic item_t mk_aligned(logic [3:0] rd, logic [3:0] rf, logic [7:0] q);
        item_t w;
        w = rand_fields(OP_ALIGNED);
        w.read_nt = rd;
        w.ref_nt  = rf;
        w.quality = q;
        return w;
    endfunction

    task automatic push_word(input item_t w);
        feed_t f;
        f.kind  = WORD_ITEM;
        f.w     = w;
        f.limit = '0;
        feed_q.push_back(f);
        n_words++;
    endtask

    // Drain everything in flight, then load a new limit.
    task automatic push_limit(input logic [30:0] v);
        feed_t f;
        f.w     = rand_fields(OP_END);
        f.limit = v;
        f.kind  = DRAIN_WAIT;
        feed_q.push_back(f);
        f.kind  = CFG_WRITE;
        feed_q.push_back(f);
        gen_limit = v;
    endtask

    // One read: start, left clip, aligned/insert/deletion body, right clip, end.
    task automatic add_read(input int nb);
        item_t w;
        int    lc, rc, tail2, i, span;
        bit    is_rev, in_run, mm;
        w = rand_fields(OP_START);
        is_rev = w.reverse;
        case ($urandom_range(0, 9))
            0: ;                                            // any length, may exceed max
            1: w.read_length = 13'(nb + $urandom_range(1, 5)); // missing bases
            2: w.read_length = 13'((nb > 3) ? nb - $urandom_range(1, 3) : 0);
            default: w.read_length = 13'(nb);
        endcase
        // land near the limit so some reads cross it mid-way
        if (gen_limit != 0 && $urandom_range(0, 2) == 0) begin
            span = 2 * nb + 4;
            if (gen_limit > span)
                w.ref_start = gen_limit - 31'($urandom_range(0, span));
            else
                w.ref_start = 31'($urandom_range(0, gen_limit));
        end
        push_word(w);

        lc = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        rc = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        if (lc + rc > nb) begin
            lc = 0;
            rc = 0;
        end
        tail2  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        in_run = 1'b0;
        for (i = 0; i < nb; i++) begin
            if (i < lc || i >= nb - rc) begin
                w = rand_fields(OP_SOFTCLIP);
                w.first_of_run = (i == 0 || i == nb - rc);
            end
            else begin
                if ($urandom_range(0, 9) == 0) begin
                    w = rand_fields(OP_DELETION);
                    if ($urandom_range(0, 7) != 0)
                        w.del_length = 28'($urandom_range(1, 50));
                    push_word(w);
                end
                if ($urandom_range(0, 9) == 0) begin
                    w = rand_fields(OP_INSERT);
                    in_run = 1'b0;
                end
                else begin
                    w  = rand_fields(OP_ALIGNED);
                    mm = in_run ? ($urandom_range(0, 9) < 6) : ($urandom_range(0, 9) < 2);
                    in_run = mm;
                    // one in twenty keeps random codes (unknown read, N reference)
                    if ($urandom_range(0, 19) != 0) begin
                        w.ref_nt = 4'($urandom_range(0, 14));
                        if (mm) begin
                            do
                                w.read_nt = 4'($urandom_range(1, 15));
                            while (w.read_nt == w.ref_nt);
                        end
                        else
                            w.read_nt = w.ref_nt;
                    end
                end
            end
            // 3' tail of quality 2: high indices forward, low indices reverse
            if (is_rev ? (i < tail2) : (i >= nb - tail2))
                w.quality = TAIL_QUAL;
            else if ($urandom_range(0, 15) == 0)
                w.quality = TAIL_QUAL;
            push_word(w);
        end
        // mostly one end word; sometimes none (broken read), sometimes two
        case ($urandom_range(0, 19))
            0: ;
            1: begin
                push_word(rand_fields(OP_END));
                push_word(rand_fields(OP_END));
            end
            default: push_word(rand_fields(OP_END));
        endcase
    endtask

    task automatic build_stimulus();
        item_t       w;
        int          i, ph, target;
        logic [30:0] limits[6];
        limits[0] = 31'h7FFFFFFF;
        limits[1] = 31'd1;
        limits[2] = 31'($urandom);
        limits[3] = 31'd0;
        limits[4] = 31'($urandom_range(1, 5000));
        limits[5] = 31'h40000000;

        // words before any start apply to the reset state
        push_word(mk_aligned(4'd3, 4'd5, 8'd30));
        w = rand_fields(OP_SOFTCLIP);
        w.first_of_run = 1'b1;
        push_word(w);
        push_word(rand_fields(OP_SPARE_A));
        push_word(rand_fields(OP_SPARE_B));
        push_word(rand_fields(OP_END));

        // overlong length clamps; unknown read base and N reference never count
        w = rand_fields(OP_START);
        w.ref_start   = 31'd100;
        w.read_length = '1;
        w.reverse     = 1'b0;
        push_word(w);
        push_word(mk_aligned(BASE_UNKNOWN, 4'd7, 8'd200));
        push_word(mk_aligned(4'd7, BASE_N, 8'd200));
        push_word(mk_aligned(4'd1, 4'd2, 8'd255));
        push_word(mk_aligned(4'd2, 4'd1, 8'd10));   // adjacent: run keeps max
        w = rand_fields(OP_DELETION);
        w.del_length = '1;
        push_word(w);
        push_word(mk_aligned(4'd4, 4'd8, 8'd0));    // still adjacent in read index
        w = rand_fields(OP_INSERT);
        w.quality = TAIL_QUAL;
        push_word(w);
        push_word(mk_aligned(4'd8, 4'd4, 8'd77));   // gap: new run
        push_word(rand_fields(OP_END));
        push_word(rand_fields(OP_END));             // repeated end, same summary

        // reverse strand with a left clip and a quality-2 head
        w = rand_fields(OP_START);
        w.ref_start   = 31'd0;
        w.read_length = 13'd5;
        w.reverse     = 1'b1;
        push_word(w);
        w = rand_fields(OP_SOFTCLIP);
        w.first_of_run = 1'b1;
        w.quality      = TAIL_QUAL;
        push_word(w);
        w = rand_fields(OP_SOFTCLIP);
        w.first_of_run = 1'b0;
        w.quality      = 8'd9;
        push_word(w);
        push_word(mk_aligned(4'd2, 4'd2, TAIL_QUAL));
        push_word(rand_fields(OP_END));

        for (ph = 0; ph < 6; ph++) begin
            push_limit(limits[ph]);
            if (ph == 0) begin
                // reference position saturates instead of wrapping past the limit
                w = rand_fields(OP_START);
                w.ref_start   = 31'h7FFFFFFF;
                w.read_length = 13'd2;
                push_word(w);
                for (i = 0; i < 9; i++) begin
                    w = rand_fields(OP_DELETION);
                    w.del_length = '1;
                    push_word(w);
                end
                push_word(mk_aligned(4'd1, 4'd2, 8'd40));
                push_word(rand_fields(OP_END));
            end
            target = n_words + PHASE_WORDS;
            while (n_words < target) begin
                if ($urandom_range(0, 11) == 0)
                    push_word(rand_fields(3'($urandom_range(0, 7))));
                else
                    add_read(($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                         : $urandom_range(0, 30));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Read tracking: applies one accepted word, queues a summary on end
    // ------------------------------------------------------------------
    task automatic track_read(input item_t w);
        int          idx, q2, tpi;
        logic [32:0] pos_sum;
        int unsigned total;
        summary_t    s;
        case (w.op)
            OP_START: begin
                rd_idx      = 0;
                base_cnt    = 0;
                mm_sum      = 0;
                last_mm_idx = -1;
                last_mm_q   = 0;
                lclip       = 0;
                clip_left   = 1'b0;
                still_ok    = 1'b1;
                tail_found  = 1'b0;
                tail_idx    = -1;
                rlen        = (w.read_length > LEN_MAX) ? MAX_READ_LEN : int'(w.read_length);
                ref_pos     = {1'b0, w.ref_start};
                rclip_edge  = rlen;
                unclipped   = rlen;
                rev         = w.reverse;
            end
            OP_DELETION: begin
                if (still_ok) begin
                    pos_sum = ref_pos + {5'b0, w.del_length};
                    ref_pos = pos_sum[32] ? '1 : pos_sum[31:0];
                end
            end
            OP_ALIGNED, OP_INSERT, OP_SOFTCLIP: begin
                if (base_cnt < MAX_READ_LEN) begin
                    idx = base_cnt;
                    base_cnt++;
                    // forward keeps the last non-2 base, reverse the first
                    if (idx < rlen && w.quality != TAIL_QUAL) begin
                        if (!rev || !tail_found)
                            tail_idx = idx;
                        tail_found = 1'b1;
                    end
                    if (still_ok) begin
                        if (w.op == OP_ALIGNED) begin
                            if (len_limit != 0 && ref_pos > {1'b0, len_limit})
                                still_ok = 1'b0;
                            else begin
                                if (w.read_nt != w.ref_nt && w.ref_nt != BASE_N
                                    && w.read_nt != BASE_UNKNOWN) begin
                                    if (last_mm_idx != -1 && last_mm_idx + 1 != rd_idx) begin
                                        total     = mm_sum + last_mm_q;
                                        mm_sum    = (total > SUM_MAX) ? SUM_MAX : total;
                                        last_mm_q = w.quality;
                                    end
                                    else if (last_mm_idx == -1 || last_mm_q < w.quality)
                                        last_mm_q = w.quality;
                                    last_mm_idx = rd_idx;
                                end
                                pos_sum  = ref_pos + 33'd1;
                                ref_pos  = pos_sum[32] ? '1 : pos_sum[31:0];
                                rd_idx++;
                            end
                        end
                        else if (w.op == OP_INSERT)
                            rd_idx++;
                        else begin
                            if (w.first_of_run)
                                clip_left = (rd_idx == 0);
                            if (clip_left)
                                lclip++;
                            else
                                rclip_edge--;
                            rd_idx++;
                            unclipped--;
                        end
                    end
                end
            end
            OP_END: begin
                q2 = tail_found ? tail_idx - 1 : -1;
                if (rev) begin
                    tpi = (lclip > 0) ? lclip : 0;
                    if (q2 > tpi)
                        tpi = q2;
                end
                else begin
                    tpi = rlen - 1;
                    if (rclip_edge < tpi)
                        tpi = rclip_edge;
                    if (q2 != -1 && q2 < tpi)
                        tpi = q2;
                end
                total = mm_sum + last_mm_q;
                s.mismatch_quality_sum = (total > SUM_MAX) ? SUM_MAX : 20'(total);
                s.kept_len             = 14'(unclipped);
                s.head_clip            = 13'(lclip);
                s.end3_bound           = 14'(tpi);
                s.q2_position          = 13'(q2);
                s.aborted              = !still_ok;
                summary_q.push_back(s);
            end
            default: ;   // unused op codes
        endcase
    endtask

    function automatic void cmp_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: next word, stalls, drains and limit writes at the falling edge
    // ------------------------------------------------------------------
    wire calm = (cycles >= CALM_LO && cycles < CALM_HI);

    always @(negedge clk) begin : drive_blk
        logic  nv;
        logic  nwe;
        feed_t f;
        nv  = s_axis_tvalid;
        nwe = 1'b0;
        if (rst_n && (!s_axis_tvalid || in_fire)) begin
            nv = 1'b0;
            if (feed_q.size() != 0) begin
                case (feed_q[0].kind)
                    WORD_ITEM: begin
                        if (calm || $urandom_range(0, 99) >= 20) begin
                            f = feed_q.pop_front();
                            cur_word = f.w;
                            s_axis_tdata <= {6'b0, f.w.first_of_run, f.w.del_length,
                                             f.w.quality, f.w.ref_nt, f.w.read_nt,
                                             f.w.reverse, f.w.read_length, f.w.ref_start};
                            s_axis_tuser <= f.w.op;
                            nv = 1'b1;
                        end
                    end
                    DRAIN_WAIT: begin
                        // quiet input, no summary owed, then the SETTLE wait
                        if (summary_q.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt == SETTLE) begin
                            settle_cnt = 0;
                            void'(feed_q.pop_front());
                        end
                        else
                            settle_cnt++;
                    end
                    default: begin
                        f = feed_q.pop_front();
                        cfg_wdata <= f.limit;
                        nwe = 1'b1;
                    end
                endcase
            end
        end
        s_axis_tvalid <= nv;
        cfg_we        <= nwe;
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // ------------------------------------------------------------------
    // Monitor and tracking at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : mon_blk
        summary_t got, want;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n) begin
            if (cfg_we)
                len_limit = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                got.mismatch_quality_sum = m_axis_tdata[19:0];
                got.kept_len             = m_axis_tdata[33:20];
                got.head_clip            = m_axis_tdata[46:34];
                got.end3_bound           = m_axis_tdata[60:47];
                got.q2_position          = m_axis_tdata[73:61];
                got.aborted              = m_axis_tdata[74];
                if (summary_q.size() == 0) begin
                    $display("%0t: summary word with none expected, got %0h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else begin
                    want = summary_q.pop_front();
                    cmp_field("mismatch_quality_sum", want.mismatch_quality_sum,
                              got.mismatch_quality_sum);
                    cmp_field("kept_len", want.kept_len, got.kept_len);
                    cmp_field("head_clip", want.head_clip, got.head_clip);
                    cmp_field("end3_bound", want.end3_bound, got.end3_bound);
                    cmp_field("q2_position", want.q2_position, got.q2_position);
                    cmp_field("aborted", want.aborted, got.aborted);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                track_read(cur_word);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (feed_q.size() != 0 || s_axis_tvalid || summary_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/rmqs_pkg.sv
design/rmqs_acc.sv
design/read_mismatch_quality_summary.sv
design/rmqs_chk.sv
tb/tb_top.sv
